// File: design/set_associative_lru_cache_defines.svh
// Assertion macros for the set-associative LRU cache checker.
// Standalone header; used by sac_checker only.
`ifndef SET_ASSOCIATIVE_LRU_CACHE_DEFINES_SVH
`define SET_ASSOCIATIVE_LRU_CACHE_DEFINES_SVH

// Next-cycle implication, disabled while reset is asserted.
`define SAC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also covers the reset cycles.
`define SAC_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/sac_pkg.sv
// Shared types, constants and geometry function for the LRU cache.
// No dependencies.
package sac_pkg;

    localparam int LINES           = 1024;
    localparam int MAX_WAYS        = 16;
    localparam int AGE_BITS        = 32;
    localparam int LINE_SHIFT      = 5;
    localparam int ASSOC_LINES     = (16 * 1024) / 32;
    localparam int ASSOC_LOG2      = $clog2(ASSOC_LINES);
    localparam int LINES_LOG2      = $clog2(LINES);
    localparam int COL_W           = $clog2(MAX_WAYS);
    localparam int ROWS            = LINES / MAX_WAYS;
    localparam int ROW_W           = $clog2(ROWS);
    localparam int WL_W            = $clog2(COL_W + 1);
    localparam int SB_W            = $clog2(LINES_LOG2 + 1);
    localparam int TAG_W           = 23;
    localparam int ADDR_W          = 32;
    localparam int KB_W            = 3;
    localparam int DIRECT_KB_MAX   = 5;
    localparam int DIRECT_SET_BASE = 5;
    localparam int Q_DEPTH         = 2;
    localparam int IN_W            = 40;
    localparam int OUT_W           = 72;

    // configuration register indexes
    localparam logic [1:0] CFG_WAYS   = 2'd0;
    localparam logic [1:0] CFG_POLICY = 2'd1;
    localparam logic [1:0] CFG_DIRECT = 2'd2;

    // policy codes
    localparam logic [1:0] POL_PLAIN    = 2'd0;
    localparam logic [1:0] POL_NO_ALLOC = 2'd1;
    localparam logic [1:0] POL_PF_ALL   = 2'd2;
    localparam logic [1:0] POL_PF_MISS  = 2'd3;

    typedef struct packed {
        logic                valid;
        logic [TAG_W-1:0]    tag;
        logic [AGE_BITS-1:0] age;
    } line_t;

    typedef line_t [MAX_WAYS-1:0] row_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [TAG_W-1:0] tag;
    } geo_t;

    typedef struct packed {
        logic            store;
        logic            allocate;
        logic            pf_all;
        logic            pf_miss;
        logic [WL_W-1:0] wl;
        geo_t            dem;
        geo_t            pf;
    } desc_t;

    // Locate a line: memory row, column within the row, and tag.
    function automatic geo_t line_geo(input logic [ADDR_W:0] a, input logic direct,
                                      input logic [WL_W-1:0] wl,
                                      input logic [KB_W-1:0] kbl);
        logic [ADDR_W-LINE_SHIFT:0] ln;
        logic [SB_W-1:0]            sb;
        logic [KB_W-1:0]            k;
        logic [LINES_LOG2-1:0]      mask;
        logic [LINES_LOG2-1:0]      entry;
        geo_t                       g;
        ln = a[ADDR_W:LINE_SHIFT];
        k  = (kbl > KB_W'(DIRECT_KB_MAX)) ? KB_W'(DIRECT_KB_MAX) : kbl;
        if (direct) begin
            sb = SB_W'(DIRECT_SET_BASE) + SB_W'(k);
            if (sb > SB_W'(LINES_LOG2)) sb = SB_W'(LINES_LOG2);
        end else begin
            sb = SB_W'(ASSOC_LOG2) - SB_W'(wl);
        end
        mask  = ~({LINES_LOG2{1'b1}} << sb);
        entry = (ln[LINES_LOG2-1:0] & mask) << wl;
        g.row = entry[LINES_LOG2-1:COL_W];
        g.col = entry[COL_W-1:0];
        g.tag = TAG_W'(ln >> sb);
        return g;
    endfunction

endpackage

// File: design/set_associative_lru_cache.sv
// Top level of the set-associative LRU cache tag model.
// Depends on sac_pkg, sac_front, sac_queue, sac_back.
//
// Usage:
//   Input stream s_*: one transfer per demand access (load or store + address).
//   Output stream m_*: one transfer per access with hit flag and the running
//   hit and access counts, this access included.
//   Config channel cfg_*: index 0 ways_log2, 1 policy_mode, 2 direct_kb_log2;
//   always ready; write only while the block is idle.
//   Result path: the access is queued, then taken with its row read, then evaluated
//   into the result register behind m_tvalid. A new access starts only after the row
//   is read and rewritten, and after the next-line prefetch row when one runs.
//   A row holds all ways of a set, so one read serves the whole lookup.
//   Reset: aresetn (synchronous, active low) clears counters and config, then
//   a clearing pass sweeps the 64 memory rows with s_tready low.
//   Receiver stall: the result register holds; up to two more accesses queue
//   up before s_tready drops.
module set_associative_lru_cache import sac_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [KB_W-1:0]  cfg_data,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // [0] command, [32:1] address, rest zero
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // [0] hit, [32:1] hit_count, [64:33] access_count
);

    logic              clearing;
    logic              q_push, q_full, q_pop, q_valid;
    desc_t             q_din, q_dout;
    logic              hit;
    logic [ADDR_W-1:0] hit_count, access_count;

    // Classify accesses and hold the configuration.
    sac_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .clearing  (clearing),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_din     (q_din)
    );

    // Decouple classification from the memory work.
    sac_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (q_din),
        .full    (q_full),
        .pop     (q_pop),
        .valid   (q_valid),
        .dout    (q_dout)
    );

    // Look up, replace, count and hold the result.
    sac_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_dout       (q_dout),
        .q_pop        (q_pop),
        .clearing     (clearing),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .hit          (hit),
        .hit_count    (hit_count),
        .access_count (access_count)
    );

    // Pack the result fields, lowest field first, zero pad to whole bytes.
    assign m_tdata = {(OUT_W - 2*ADDR_W - 1)'(0), access_count, hit_count, hit};

endmodule

// File: design/sac_front.sv
// Front end: configuration registers and classification of accesses.
// Depends on sac_pkg.
module sac_front import sac_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [KB_W-1:0]  cfg_data,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,
    input  logic             clearing,
    input  logic             q_full,
    output logic             q_push,
    output desc_t            q_din
);

    logic [KB_W-1:0] ways_log2_reg, ways_log2_next;
    logic [1:0]      policy_reg, policy_next;
    logic [KB_W-1:0] direct_kb_reg, direct_kb_next;
    logic [WL_W-1:0] wl_eff;
    logic            direct;
    logic            store;
    logic [ADDR_W:0] a_dem, a_pf;

    assign cfg_ready = 1'b1;

    always_comb begin
        ways_log2_next = ways_log2_reg;
        policy_next    = policy_reg;
        direct_kb_next = direct_kb_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_WAYS:   ways_log2_next = cfg_data;
                CFG_POLICY: policy_next    = cfg_data[1:0];
                CFG_DIRECT: direct_kb_next = cfg_data;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ways_log2_reg <= '0;
            policy_reg    <= POL_PLAIN;
            direct_kb_reg <= KB_W'(4);
        end else begin
            ways_log2_reg <= ways_log2_next;
            policy_reg    <= policy_next;
            direct_kb_reg <= direct_kb_next;
        end
    end

    // Clamp associativity to what the row holds.
    assign wl_eff = (ways_log2_reg > KB_W'(COL_W)) ? WL_W'(COL_W) : WL_W'(ways_log2_reg);
    assign direct = (wl_eff == '0);
    assign store  = s_tdata[0];
    assign a_dem  = {1'b0, s_tdata[ADDR_W:1]};
    assign a_pf   = a_dem + (ADDR_W+1)'(1 << LINE_SHIFT);

    assign s_tready = !clearing && !q_full;
    assign q_push   = s_tvalid && s_tready;

    always_comb begin
        q_din.store    = store;
        q_din.allocate = direct || !(policy_reg == POL_NO_ALLOC && store);
        q_din.pf_all   = !direct && (policy_reg == POL_PF_ALL);
        q_din.pf_miss  = !direct && (policy_reg == POL_PF_MISS);
        q_din.wl       = wl_eff;
        q_din.dem      = line_geo(a_dem, direct, wl_eff, direct_kb_reg);
        q_din.pf       = line_geo(a_pf, direct, wl_eff, direct_kb_reg);
    end

endmodule

// File: design/sac_queue.sv
// Short FIFO of classified accesses between front and back end.
// Depends on sac_pkg.
module sac_queue import sac_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  desc_t din,
    output logic  full,
    input  logic  pop,
    output logic  valid,
    output desc_t dout
);

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    desc_t            slot_reg [Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full  = (count_reg == CNT_W'(Q_DEPTH));
    assign valid = (count_reg != '0);
    assign dout  = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) slot_reg[wr_ptr_reg] <= din;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= (wr_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= (rd_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            count_reg <= count_reg + CNT_W'(push) - CNT_W'(pop);
        end
    end

endmodule

// File: design/sac_back.sv
// Back end: tag/age row memory, lookup and replacement, counters, result register.
// Depends on sac_pkg.
module sac_back import sac_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    input  desc_t             q_dout,
    output logic              q_pop,
    output logic              clearing,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic              hit,
    output logic [ADDR_W-1:0] hit_count,
    output logic [ADDR_W-1:0] access_count
);

    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_EVAL, S_PF_READ, S_PF_EVAL} state_t;

    state_t            state_reg;
    desc_t             cur_reg;
    logic [ROW_W-1:0]  clr_reg;
    logic              out_valid_reg;
    logic              out_hit_reg;
    logic [ADDR_W-1:0] hit_total_reg, access_total_reg;

    row_t              mem [ROWS];
    row_t              rdata_reg;
    logic [ROW_W-1:0]  rd_row;
    logic              we;
    logic [ROW_W-1:0]  wr_row;
    row_t              wr_data;

    geo_t              g;
    logic              alloc;
    logic [COL_W-1:0]  grp_mask;
    logic [MAX_WAYS-1:0] in_set, match;
    logic [AGE_BITS-1:0] aged [MAX_WAYS];
    logic [1:0]          t_rank [1:2*MAX_WAYS-1];
    logic [AGE_BITS-1:0] t_age  [1:2*MAX_WAYS-1];
    logic [COL_W-1:0]    t_idx  [1:2*MAX_WAYS-1];
    logic                look_hit;
    logic [COL_W-1:0]    victim;
    row_t                new_row;
    logic                start;
    logic                go_pf;

    // ---- row memory ----
    assign rd_row = (state_reg == S_PF_READ) ? cur_reg.pf.row : q_dout.dem.row;

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[rd_row];
    end

    always_ff @(posedge aclk) begin
        if (we) mem[wr_row] <= wr_data;
    end

    // ---- lookup over one row ----
    assign g        = (state_reg == S_PF_EVAL) ? cur_reg.pf : cur_reg.dem;
    assign alloc    = (state_reg == S_PF_EVAL) ? 1'b1 : cur_reg.allocate;
    assign grp_mask = {COL_W{1'b1}} << cur_reg.wl;

    always_comb begin
        for (int i = 0; i < MAX_WAYS; i++) begin
            in_set[i] = (((COL_W'(i)) ^ g.col) & grp_mask) == '0;
            match[i]  = in_set[i] && rdata_reg[i].valid && (rdata_reg[i].tag == g.tag);
            aged[i]   = (rdata_reg[i].age == {AGE_BITS{1'b1}}) ? rdata_reg[i].age
                                                               : rdata_reg[i].age + 1'b1;
        end
        look_hit = |match;
    end

    // Victim tree: invalid way first, then oldest, ties to the lower way.
    always_comb begin
        for (int i = 0; i < MAX_WAYS; i++) begin
            t_rank[MAX_WAYS+i] = !in_set[i] ? 2'd0 : (rdata_reg[i].valid ? 2'd1 : 2'd2);
            t_age[MAX_WAYS+i]  = aged[i];
            t_idx[MAX_WAYS+i]  = COL_W'(i);
        end
        for (int n = MAX_WAYS - 1; n >= 1; n--) begin
            if (t_rank[2*n+1] > t_rank[2*n] ||
                (t_rank[2*n+1] == 2'd1 && t_rank[2*n] == 2'd1 &&
                 t_age[2*n+1] > t_age[2*n])) begin
                t_rank[n] = t_rank[2*n+1];
                t_age[n]  = t_age[2*n+1];
                t_idx[n]  = t_idx[2*n+1];
            end else begin
                t_rank[n] = t_rank[2*n];
                t_age[n]  = t_age[2*n];
                t_idx[n]  = t_idx[2*n];
            end
        end
        victim = t_idx[1];
    end

    always_comb begin
        new_row = rdata_reg;
        for (int i = 0; i < MAX_WAYS; i++) begin
            // direct-mapped entries keep their ages
            if (in_set[i] && cur_reg.wl != '0) new_row[i].age = match[i] ? '0 : aged[i];
            if (!look_hit && alloc && COL_W'(i) == victim) begin
                new_row[i].valid = 1'b1;
                new_row[i].tag   = g.tag;
                if (cur_reg.wl != '0) new_row[i].age = '0;
            end
        end
    end

    // ---- control ----
    assign start = (state_reg == S_IDLE) && q_valid && (!out_valid_reg || m_tready);
    assign q_pop = start;
    assign go_pf = cur_reg.pf_all || (cur_reg.pf_miss && !look_hit);

    always_comb begin
        we      = 1'b0;
        wr_row  = g.row;
        wr_data = new_row;
        unique case (state_reg)
            S_CLEAR: begin
                we      = 1'b1;
                wr_row  = clr_reg;
                wr_data = '0;
            end
            S_EVAL, S_PF_EVAL: we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_CLEAR;
            clr_reg          <= '0;
            out_valid_reg    <= 1'b0;
            hit_total_reg    <= '0;
            access_total_reg <= '0;
        end else begin
            if (out_valid_reg && m_tready) out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == ROW_W'(ROWS - 1)) state_reg <= S_IDLE;
                end
                S_IDLE: begin
                    if (start) begin
                        cur_reg   <= q_dout;
                        state_reg <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    out_valid_reg    <= 1'b1;
                    out_hit_reg      <= look_hit;
                    access_total_reg <= access_total_reg + 1'b1;
                    if (look_hit) hit_total_reg <= hit_total_reg + 1'b1;
                    state_reg <= go_pf ? S_PF_READ : S_IDLE;
                end
                S_PF_READ: state_reg <= S_PF_EVAL;
                S_PF_EVAL: state_reg <= S_IDLE;
                default:   state_reg <= S_IDLE;
            endcase
        end
    end

    assign clearing     = (state_reg == S_CLEAR);
    assign m_tvalid     = out_valid_reg;
    assign hit          = out_hit_reg;
    assign hit_count    = hit_total_reg;
    assign access_count = access_total_reg;

endmodule

// File: design/sac_checker.sv
// Port-level checker for the LRU cache, bound to the top level.
// Depends on set_associative_lru_cache_defines.svh.
`include "set_associative_lru_cache_defines.svh"

module sac_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata
);

    // A stalled result holds.
    `SAC_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed under stall")

    // Back-to-back results carry distinct access counts.
    `SAC_ASSERT_NEXT(a_count, aclk, aresetn, m_tvalid && m_tready, !m_tvalid || (m_tdata[64:33] != $past(m_tdata[64:33])), "access count repeated")

    // No input is taken during reset or right after it (clearing pass).
    `SAC_ASSERT_NEXT_ALWAYS(a_clear, aclk, !aresetn, !s_tready, "input taken during clear")

endmodule

bind set_associative_lru_cache sac_checker u_sac_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for set_associative_lru_cache: directed, sweep, then random
// access streams, every result checked against a tag/age predictor. Depends on sac_pkg.
module testbench;
    import sac_pkg::*;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [1:0]       cfg_index = '0;
    logic [KB_W-1:0]  cfg_data = '0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata = '0;    // [0] command, [32:1] address
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;         // [0] hit, [32:1] hit_count, [64:33] access_count

    set_associative_lru_cache dut (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Predictor state: tags, valid bits and ages of every entry, counters and config.
    logic [TAG_W-1:0]    tag_mem   [LINES];
    logic                valid_mem [LINES];
    logic [AGE_BITS-1:0] age_mem   [LINES];
    logic [31:0]         hits_seen, accesses_seen;
    logic [2:0]          ways_cfg, kb_cfg;
    logic [1:0]          policy_cfg;

    typedef struct packed {
        logic        hit;
        logic [31:0] hit_count;
        logic [31:0] access_count;
    } cache_result_t;

    cache_result_t expected_results[$];
    int  errors = 0;
    bit  stall_long = 0;

    // One set lookup in associative mode; returns the hit flag.
    function automatic logic lookup_set(input logic [32:0] a, input int wl, input logic alloc);
        int          ways, sb, base, e, victim;
        logic [31:0] set_idx;
        logic [TAG_W-1:0] t;
        logic [AGE_BITS-1:0] oldest;
        logic        hit;
        ways = 1 << wl;
        sb = ASSOC_LOG2 - wl;
        set_idx = 32'((a >> LINE_SHIFT) & ((33'd1 << sb) - 1));
        t = TAG_W'(a >> (LINE_SHIFT + sb));
        base = int'(set_idx) * ways;
        hit = 1'b0;
        for (int w = 0; w < ways; w++) begin
            e = (base + w) % LINES;
            if (age_mem[e] != '1) age_mem[e]++;
            if (valid_mem[e] && tag_mem[e] == t) begin
                hit = 1'b1;
                age_mem[e] = '0;
            end
        end
        if (!hit && alloc) begin
            victim = 0;
            oldest = '0;
            for (int w = 0; w < ways; w++) begin
                e = (base + w) % LINES;
                if (!valid_mem[e]) begin
                    victim = w;
                    break;
                end
                if (age_mem[e] > oldest) begin
                    oldest = age_mem[e];
                    victim = w;
                end
            end
            e = (base + victim) % LINES;
            tag_mem[e] = t;
            age_mem[e] = '0;
            valid_mem[e] = 1'b1;
        end
        return hit;
    endfunction

    function automatic cache_result_t predict_access(input logic store, input logic [31:0] addr);
        int   wl, sb, e;
        logic [TAG_W-1:0] t;
        logic hit;
        cache_result_t r;
        wl = (ways_cfg > 4) ? 4 : int'(ways_cfg);
        if (wl == 0) begin
            sb = 5 + ((kb_cfg > 5) ? 5 : int'(kb_cfg));
            if (sb > LINES_LOG2) sb = LINES_LOG2;
            e = int'((addr >> LINE_SHIFT) & ((32'd1 << sb) - 1));
            t = TAG_W'(addr >> (LINE_SHIFT + sb));
            hit = valid_mem[e] && tag_mem[e] == t;
            if (!hit) begin
                tag_mem[e] = t;
                valid_mem[e] = 1'b1;
            end
        end else begin
            hit = lookup_set({1'b0, addr}, wl, !(policy_cfg == POL_NO_ALLOC && store));
            if (policy_cfg == POL_PF_ALL || (policy_cfg == POL_PF_MISS && !hit))
                void'(lookup_set({1'b0, addr} + 33'd32, wl, 1'b1));
        end
        accesses_seen++;
        if (hit) hits_seen++;
        r.hit = hit;
        r.hit_count = hits_seen;
        r.access_count = accesses_seen;
        return r;
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [2:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_WAYS:   ways_cfg   = val;
            CFG_POLICY: policy_cfg = val[1:0];
            default:    kb_cfg     = val;
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Drive one access; the expectation is queued at the accepting edge.
    task automatic send_access(input logic store, input logic [31:0] addr,
                               input bit has_fixed, input cache_result_t fixed);
        cache_result_t r;
        repeat ($urandom_range(0, 7) * ($urandom_range(0, 3) != 0)) @(negedge aclk);
        s_tdata  <= {7'd0, addr, store};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        r = predict_access(store, addr);
        if (has_fixed && r != fixed) begin
            $display("%0t: table row disagrees with predictor: table %h predictor %h",
                     $time, fixed, r);
            errors++;
        end
        expected_results.push_back(r);
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic drain;
        while (expected_results.size() != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
    endtask

    // Receiver: random stalls, with one long hold-off on request.
    initial begin
        int gap;
        forever begin
            @(negedge aclk);
            if (stall_long) begin
                m_tready <= 1'b0;
                for (int i = 0; i < 60; i++) @(negedge aclk);
                stall_long = 0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            if (gap != 0) begin
                m_tready <= 1'b0;
                for (int i = 0; i < gap; i++) @(negedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // Compare every result transfer with the oldest expectation.
    always @(posedge aclk) begin
        cache_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.hit          = m_tdata[0];
            got.hit_count    = m_tdata[32:1];
            got.access_count = m_tdata[64:33];
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (got.hit !== want.hit)
                    $display("%0t: hit expected %0d actual %0d", $time, want.hit, got.hit);
                if (got.hit_count !== want.hit_count)
                    $display("%0t: hit_count expected %0d actual %0d",
                             $time, want.hit_count, got.hit_count);
                if (got.access_count !== want.access_count)
                    $display("%0t: access_count expected %0d actual %0d",
                             $time, want.access_count, got.access_count);
                if (got !== want) errors++;
            end
        end
    end

    typedef struct {
        logic        store;
        logic [31:0] addr;
        bit          fixed;
        logic        hit;
        logic [31:0] hits;
        logic [31:0] total;
    } access_row_t;

    // Directed rows, run in default direct-mapped 16 KB mode after reset.
    access_row_t directed[] = '{
        '{1'b0, 32'h0000_0000, 1, 1'b0, 32'd0, 32'd1},   // cold miss
        '{1'b0, 32'h0000_001F, 1, 1'b1, 32'd1, 32'd2},   // same line hits
        '{1'b1, 32'hFFFF_FFFF, 1, 1'b0, 32'd1, 32'd3},   // top address miss
        '{1'b1, 32'hFFFF_FFE0, 1, 1'b1, 32'd2, 32'd4},
        '{1'b0, 32'h0000_4000, 1, 1'b0, 32'd2, 32'd5},   // conflict evicts line 0
        '{1'b0, 32'h0000_0000, 1, 1'b0, 32'd2, 32'd6},
        '{1'b1, 32'hAAAA_AAAA, 0, 1'b0, 32'd0, 32'd0},
        '{1'b0, 32'h5555_5555, 0, 1'b0, 32'd0, 32'd0}
    };

    task automatic random_phase(input int n, input int span);
        logic [31:0] a;
        for (int i = 0; i < n; i++) begin
            // mostly a small address pool for reuse, sometimes any address
            if ($urandom_range(0, 9) == 0) a = $urandom();
            else a = {2'($urandom_range(0, 3)), 15'd0, 15'($urandom_range(0, span))};
            send_access(1'($urandom_range(0, 1)), a, 1'b0, '0);
        end
    endtask

    initial begin
        for (int i = 0; i < LINES; i++) begin
            valid_mem[i] = 1'b0;
            age_mem[i] = '0;
            tag_mem[i] = '0;
        end
        hits_seen = '0;
        accesses_seen = '0;
        ways_cfg = 3'd0;
        policy_cfg = POL_PLAIN;
        kb_cfg = 3'd4;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed[i])
            send_access(directed[i].store, directed[i].addr, directed[i].fixed,
                        '{directed[i].hit, directed[i].hits, directed[i].total});
        // every associativity and policy, plus out-of-range codes
        for (int w = 1; w <= 5; w++)
            for (int p = 0; p < 4; p++) begin
                drain();
                write_reg(CFG_WAYS, 3'(w));
                write_reg(CFG_POLICY, 3'(p));
                send_access(1'b1, 32'hFFFF_FFE0, 1'b0, '0);   // prefetch past the top
                send_access(1'b0, 32'hFFFF_FFE0, 1'b0, '0);
            end
        for (int ph = 0; ph < 24; ph++) begin
            drain();
            write_reg(CFG_WAYS, 3'($urandom_range(0, 7)));
            write_reg(CFG_POLICY, 3'($urandom_range(0, 3)));
            write_reg(CFG_DIRECT, 3'($urandom_range(0, 7)));
            if (ph == 3) stall_long = 1;
            random_phase(65, (ph % 3 == 0) ? 32767 : 2047);
        end
        drain();
        // saturate ages quickly is not feasible; keep extremes of direct size
        write_reg(CFG_WAYS, 3'd0);
        write_reg(CFG_DIRECT, 3'd0);
        random_phase(20, 4095);
        drain();
        write_reg(CFG_DIRECT, 3'd7);
        random_phase(20, 32767);
        drain();
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #(5_000_000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
